// File: rtl/block_average_mosaic_defines.svh
// ----------------------------------------------------------------------------
// Block average mosaic assertion macros
// Shared property templates for the checker of the mosaic block.
// ----------------------------------------------------------------------------
`ifndef BLOCK_AVERAGE_MOSAIC_DEFINES_SVH
`define BLOCK_AVERAGE_MOSAIC_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define BAM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("block_average_mosaic: same-cycle property failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define BAM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("block_average_mosaic: next-cycle property failed");

`endif

// File: rtl/bam_pkg.sv
// ----------------------------------------------------------------------------
// Block average mosaic package
// Widths, register indexes and shared types of the mosaic block.
// ----------------------------------------------------------------------------
package bam_pkg;

  localparam int MAX_TILE_ROWS = 256;
  localparam int MAX_TILE      = 64;
  localparam int DIM_LIMIT     = 4096;

  localparam int DIM_W  = 13;
  localparam int POS_W  = 12;
  localparam int TS_W   = 7;
  localparam int PIX_W  = 8;
  localparam int SUM_W  = 20;
  localparam int CNT_W  = 13;
  localparam int NUM_CH = 3;

  localparam int OFS_W = (MAX_TILE > 1) ? $clog2(MAX_TILE) : 1;
  localparam int IDX_W = (MAX_TILE_ROWS > 1) ? $clog2(MAX_TILE_ROWS) : 1;

  localparam int DIV_BITS   = 4;
  localparam int DIV_CYCLES = SUM_W / DIV_BITS;
  localparam int DIVC_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_TILE   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             first;
    logic             last;
    logic             done;
    logic [POS_W-1:0] tx;
    logic [POS_W-1:0] ty;
    logic [CNT_W-1:0] cnt;
  } pos_info_t;

endpackage

// File: rtl/bam_if.sv
// ----------------------------------------------------------------------------
// Block average mosaic channels
// Valid/ready channels for the pixel stream and the tile result stream.
// ----------------------------------------------------------------------------
interface bam_pix_if;
  logic                       valid;
  logic                       ready;
  logic [bam_pkg::PIX_W-1:0] red_in;
  logic [bam_pkg::PIX_W-1:0] green_in;
  logic [bam_pkg::PIX_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                output ready);
endinterface

interface bam_tile_if;
  logic                       valid;
  logic                       ready;
  logic [bam_pkg::POS_W-1:0] tile_x;
  logic [bam_pkg::POS_W-1:0] tile_y;
  logic [bam_pkg::PIX_W-1:0] avg_red;
  logic [bam_pkg::PIX_W-1:0] avg_green;
  logic [bam_pkg::PIX_W-1:0] avg_blue;
  logic                       frame_done;

  modport source (output valid, output tile_x, output tile_y, output avg_red,
                  output avg_green, output avg_blue, output frame_done,
                  input ready);
  modport sink (input valid, input tile_x, input tile_y, input avg_red,
                input avg_green, input avg_blue, input frame_done,
                output ready);
endinterface

// File: rtl/bam_ram.sv
// ----------------------------------------------------------------------------
// Block average mosaic sum memory
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bam_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/bam_pos.sv
// ----------------------------------------------------------------------------
// Block average mosaic position tracker
// Configuration registers and column-major pixel and tile position counters.
// ----------------------------------------------------------------------------
module bam_pos (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bam_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bam_pkg::DIM_W-1:0]         cfg_data,
  input  logic                              step,
  output bam_pkg::pos_info_t                info
);

  logic [bam_pkg::DIM_W-1:0] wid_r, hgt_r;
  logic [bam_pkg::TS_W-1:0]  tsz_r;
  logic [bam_pkg::POS_W-1:0] x_r, y_r, tx_r, ty_r;
  logic [bam_pkg::POS_W-1:0] x_nxt, y_nxt, tx_nxt, ty_nxt;
  logic [bam_pkg::OFS_W-1:0] xo_r, yo_r, xo_nxt, yo_nxt;
  logic [bam_pkg::IDX_W-1:0] tr_r, tr_nxt;

  logic [bam_pkg::DIM_W-1:0] w_eff, h_eff, w_m1, h_m1, w_rem, h_rem;
  logic [bam_pkg::TS_W-1:0]  ts_eff, ts_m1, cw, ch;
  logic [2*bam_pkg::TS_W-1:0] area;
  logic x_last, y_last, xo_last, yo_last;

  always_comb begin
    if (wid_r == '0) begin
      w_eff = bam_pkg::DIM_W'(1);
    end else if (wid_r > bam_pkg::DIM_W'(bam_pkg::DIM_LIMIT)) begin
      w_eff = bam_pkg::DIM_W'(bam_pkg::DIM_LIMIT);
    end else begin
      w_eff = wid_r;
    end
    if (hgt_r == '0) begin
      h_eff = bam_pkg::DIM_W'(1);
    end else if (hgt_r > bam_pkg::DIM_W'(bam_pkg::DIM_LIMIT)) begin
      h_eff = bam_pkg::DIM_W'(bam_pkg::DIM_LIMIT);
    end else begin
      h_eff = hgt_r;
    end
    if (tsz_r == '0) begin
      ts_eff = bam_pkg::TS_W'(1);
    end else if (tsz_r > bam_pkg::TS_W'(bam_pkg::MAX_TILE)) begin
      ts_eff = bam_pkg::TS_W'(bam_pkg::MAX_TILE);
    end else begin
      ts_eff = tsz_r;
    end
  end

  assign w_m1  = w_eff - bam_pkg::DIM_W'(1);
  assign h_m1  = h_eff - bam_pkg::DIM_W'(1);
  assign ts_m1 = ts_eff - bam_pkg::TS_W'(1);

  assign x_last  = ({1'b0, x_r} == w_m1);
  assign y_last  = ({1'b0, y_r} == h_m1);
  assign xo_last = (bam_pkg::TS_W'(xo_r) == ts_m1);
  assign yo_last = (bam_pkg::TS_W'(yo_r) == ts_m1);

  // Clipped tile extent at the right and bottom edges.
  assign w_rem = w_eff - {1'b0, tx_r};
  assign h_rem = h_eff - {1'b0, ty_r};
  assign cw    = (w_rem < bam_pkg::DIM_W'(ts_eff)) ? w_rem[bam_pkg::TS_W-1:0] : ts_eff;
  assign ch    = (h_rem < bam_pkg::DIM_W'(ts_eff)) ? h_rem[bam_pkg::TS_W-1:0] : ts_eff;
  assign area  = cw * ch;

  assign info.idx   = tr_r;
  assign info.first = (xo_r == '0) && (yo_r == '0);
  assign info.last  = (xo_last || x_last) && (yo_last || y_last);
  assign info.done  = x_last && y_last;
  assign info.tx    = tx_r;
  assign info.ty    = ty_r;
  assign info.cnt   = area[bam_pkg::CNT_W-1:0];

  always_comb begin
    x_nxt  = x_r;
    y_nxt  = y_r;
    xo_nxt = xo_r;
    yo_nxt = yo_r;
    tx_nxt = tx_r;
    ty_nxt = ty_r;
    tr_nxt = tr_r;
    if (y_last) begin
      y_nxt  = '0;
      yo_nxt = '0;
      ty_nxt = '0;
      tr_nxt = '0;
      if (x_last) begin
        x_nxt  = '0;
        xo_nxt = '0;
        tx_nxt = '0;
      end else begin
        x_nxt = x_r + bam_pkg::POS_W'(1);
        if (xo_last) begin
          xo_nxt = '0;
          tx_nxt = x_r + bam_pkg::POS_W'(1);
        end else begin
          xo_nxt = xo_r + bam_pkg::OFS_W'(1);
        end
      end
    end else begin
      y_nxt = y_r + bam_pkg::POS_W'(1);
      if (yo_last) begin
        yo_nxt = '0;
        ty_nxt = y_r + bam_pkg::POS_W'(1);
        if (tr_r == bam_pkg::IDX_W'(bam_pkg::MAX_TILE_ROWS - 1)) begin
          tr_nxt = '0;
        end else begin
          tr_nxt = tr_r + bam_pkg::IDX_W'(1);
        end
      end else begin
        yo_nxt = yo_r + bam_pkg::OFS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wid_r <= bam_pkg::DIM_W'(64);
      hgt_r <= bam_pkg::DIM_W'(64);
      tsz_r <= bam_pkg::TS_W'(8);
      x_r   <= '0;
      y_r   <= '0;
      xo_r  <= '0;
      yo_r  <= '0;
      tx_r  <= '0;
      ty_r  <= '0;
      tr_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bam_pkg::REG_WIDTH:  wid_r <= cfg_data;
        bam_pkg::REG_HEIGHT: hgt_r <= cfg_data;
        bam_pkg::REG_TILE:   tsz_r <= cfg_data[bam_pkg::TS_W-1:0];
        default: ;
      endcase
      x_r  <= '0;
      y_r  <= '0;
      xo_r <= '0;
      yo_r <= '0;
      tx_r <= '0;
      ty_r <= '0;
      tr_r <= '0;
    end else if (step) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      xo_r <= xo_nxt;
      yo_r <= yo_nxt;
      tx_r <= tx_nxt;
      ty_r <= ty_nxt;
      tr_r <= tr_nxt;
    end
  end

endmodule

// File: rtl/bam_div.sv
// ----------------------------------------------------------------------------
// Block average mosaic divider
// Iterative restoring divider for the three color sums, four bits per cycle.
// ----------------------------------------------------------------------------
module bam_div (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                start,
  input  logic [bam_pkg::NUM_CH-1:0][bam_pkg::SUM_W-1:0]      dividend,
  input  logic [bam_pkg::CNT_W-1:0]                           divisor,
  output logic                                                busy,
  output logic [bam_pkg::NUM_CH-1:0][bam_pkg::PIX_W-1:0]      quotient
);

  logic                                                busy_r;
  logic [bam_pkg::DIVC_W-1:0]                          cnt_r;
  logic [bam_pkg::CNT_W-1:0]                           dsr_r;
  logic [bam_pkg::NUM_CH-1:0][bam_pkg::CNT_W-1:0]      rem_r, rem_nxt;
  logic [bam_pkg::NUM_CH-1:0][bam_pkg::SUM_W-1:0]      q_r, q_nxt;

  always_comb begin
    logic [bam_pkg::CNT_W:0]   part;
    logic [bam_pkg::CNT_W-1:0] rem_v;
    logic [bam_pkg::SUM_W-1:0] q_v;
    logic                      qbit;
    for (int l = 0; l < bam_pkg::NUM_CH; l++) begin
      rem_v = rem_r[l];
      q_v   = q_r[l];
      for (int k = 0; k < bam_pkg::DIV_BITS; k++) begin
        part = {rem_v, q_v[bam_pkg::SUM_W-1]};
        qbit = (part >= {1'b0, dsr_r});
        if (qbit) begin
          part = part - {1'b0, dsr_r};
        end
        rem_v = part[bam_pkg::CNT_W-1:0];
        q_v   = {q_v[bam_pkg::SUM_W-2:0], qbit};
      end
      rem_nxt[l] = rem_v;
      q_nxt[l]   = q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + bam_pkg::DIVC_W'(1);
      if (cnt_r == bam_pkg::DIVC_W'(bam_pkg::DIV_CYCLES - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr_r <= divisor;
      rem_r <= '0;
      q_r   <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign busy = busy_r;

  always_comb begin
    for (int l = 0; l < bam_pkg::NUM_CH; l++) begin
      quotient[l] = q_r[l][bam_pkg::PIX_W-1:0];
    end
  end

endmodule

// File: rtl/block_average_mosaic.sv
// ----------------------------------------------------------------------------
// Block average mosaic downsampler
// Averages the RGB pixels of each square tile of a column-major frame.
// Each pixel gets a sum memory read, then an add and write back, before the next.
// A tile's last pixel then waits for the iterative divider; its result is loaded
// into the output register once the divider is done and that register is free.
// Reset (rst_n low at a clock edge) sets 64 x 64 pixels with 8-pixel tiles,
// the position to the frame origin, and empties the output; sums are not cleared.
// ----------------------------------------------------------------------------
module block_average_mosaic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bam_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bam_pkg::DIM_W-1:0]     cfg_data,
  bam_pix_if.sink                       in_pix,
  bam_tile_if.source                    out_tile
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACC,
    S_DIV
  } state_t;

  state_t                                           state_r;
  logic                                             accept;
  bam_pkg::pos_info_t                               pos_info, info_r;
  logic [bam_pkg::NUM_CH-1:0][bam_pkg::PIX_W-1:0]   pix_in, pix_r;
  logic [bam_pkg::NUM_CH-1:0][bam_pkg::SUM_W-1:0]   rd_sums, new_sums;
  logic [bam_pkg::NUM_CH-1:0][bam_pkg::PIX_W-1:0]   quot;
  logic                                             div_busy, div_start, ram_we;
  logic                                             out_free;
  logic                                             out_load;

  logic                                             out_valid_r;
  logic [bam_pkg::POS_W-1:0]                        tile_x_r, tile_y_r;
  logic [bam_pkg::NUM_CH-1:0][bam_pkg::PIX_W-1:0]   avg_r;
  logic                                             done_r;

  assign in_pix.ready = (state_r == S_IDLE);
  assign accept       = in_pix.valid && in_pix.ready;

  assign pix_in[0] = in_pix.red_in;
  assign pix_in[1] = in_pix.green_in;
  assign pix_in[2] = in_pix.blue_in;

  bam_pos u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (accept),
    .info      (pos_info)
  );

  always_comb begin
    for (int l = 0; l < bam_pkg::NUM_CH; l++) begin
      if (info_r.first) begin
        new_sums[l] = bam_pkg::SUM_W'(pix_r[l]);
      end else begin
        new_sums[l] = rd_sums[l] + bam_pkg::SUM_W'(pix_r[l]);
      end
    end
  end

  assign ram_we    = (state_r == S_ACC);
  assign div_start = (state_r == S_ACC) && info_r.last;

  bam_ram #(
    .WIDTH (bam_pkg::NUM_CH * bam_pkg::SUM_W),
    .DEPTH (bam_pkg::MAX_TILE_ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (info_r.idx),
    .wdata (new_sums),
    .re    (accept),
    .raddr (pos_info.idx),
    .rdata (rd_sums)
  );

  bam_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (new_sums),
    .divisor  (info_r.cnt),
    .busy     (div_busy),
    .quotient (quot)
  );

  assign out_free = !out_valid_r || out_tile.ready;
  assign out_load = (state_r == S_DIV) && !div_busy && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tile.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            pix_r   <= pix_in;
            info_r  <= pos_info;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          state_r <= info_r.last ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (out_load) begin
            tile_x_r    <= info_r.tx;
            tile_y_r    <= info_r.ty;
            avg_r       <= quot;
            done_r      <= info_r.done;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tile.valid      = out_valid_r;
  assign out_tile.tile_x     = tile_x_r;
  assign out_tile.tile_y     = tile_y_r;
  assign out_tile.avg_red    = avg_r[0];
  assign out_tile.avg_green  = avg_r[1];
  assign out_tile.avg_blue   = avg_r[2];
  assign out_tile.frame_done = done_r;

endmodule

// File: rtl/bam_checker.sv
// ----------------------------------------------------------------------------
// Block average mosaic port checker
// Temporal checks on the channel ports of the mosaic block.
// ----------------------------------------------------------------------------
`include "block_average_mosaic_defines.svh"

module bam_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [bam_pkg::POS_W-1:0] out_tile_x,
  input logic [bam_pkg::POS_W-1:0] out_tile_y,
  input logic [bam_pkg::PIX_W-1:0] out_avg_red,
  input logic [bam_pkg::PIX_W-1:0] out_avg_green,
  input logic [bam_pkg::PIX_W-1:0] out_avg_blue,
  input logic                      out_frame_done
);

  logic [2*bam_pkg::POS_W+3*bam_pkg::PIX_W:0] out_payload;

  assign out_payload = {out_tile_x, out_tile_y, out_avg_red, out_avg_green, out_avg_blue,
                        out_frame_done};

  `BAM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))
  `BAM_ASSERT_NXT(a_in_busy_after_take, in_valid && in_ready, !in_ready)
  `BAM_ASSERT_NXT(a_no_result_after_take, in_valid && in_ready, !$rose(out_valid))
  `BAM_ASSERT_IMP(a_result_while_busy, $rose(out_valid), $past(!in_ready))

endmodule

bind block_average_mosaic bam_checker u_bam_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_pix.valid),
  .in_ready       (in_pix.ready),
  .out_valid      (out_tile.valid),
  .out_ready      (out_tile.ready),
  .out_tile_x     (out_tile.tile_x),
  .out_tile_y     (out_tile.tile_y),
  .out_avg_red    (out_tile.avg_red),
  .out_avg_green  (out_tile.avg_green),
  .out_avg_blue   (out_tile.avg_blue),
  .out_frame_done (out_tile.frame_done)
);
